// File: sv/eif_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eif_pkg
// Shared types, register codes and constants of the exponential
// integrate-and-fire neuron update unit.
// ----------------------------------------------------------------------------
package eif_pkg;

   // population and refractory window
   localparam int NEURONS          = 1024;
   localparam int IDX_W            = 10;
   localparam int CLR_W            = $clog2(NEURONS + 1);
   localparam logic [31:0] REFRACTORY_STEPS = 32'd20;

   // Q12.12 limits
   localparam logic signed [41:0] Q_MAX = 42'sd8388607;
   localparam logic signed [41:0] Q_MIN = -42'sd8388608;

   // register index codes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK_GAIN   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARPNESS   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SHARP   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK_POT    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_POT    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_POT   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_POT  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_POT   = 4'd7;

   typedef struct packed {
      logic [9:0]         neuron_index;
      logic [31:0]        step_count;
      logic signed [23:0] synaptic_input;
   } req_type;

   typedef struct packed {
      logic [9:0]         neuron_number;
      logic               spiked;
      logic signed [23:0] new_potential;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        leak_gain;
      logic [22:0]        sharpness;
      logic [23:0]        inv_sharpness;
      logic signed [23:0] leak_potential;
      logic signed [23:0] critical_potential;
      logic signed [23:0] lower_bound_potential;
      logic signed [23:0] threshold_potential;
      logic signed [23:0] reset_potential;
   } cfg_type;

   // one neuron's stored state
   typedef struct packed {
      logic               has_spiked;
      logic [31:0]        last_spike;
      logic signed [23:0] potential;
   } state_type;

endpackage
`default_nettype wire

// File: sv/eif_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eif_csr
// Configuration registers, written through a valid/ready port.
// ----------------------------------------------------------------------------
module eif_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [eif_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [23:0]                   csr_data,
   output eif_pkg::cfg_type                   cfg
);
   import eif_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // decode and store the written register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leak_gain             <= 16'd655;
         cfg_ff.sharpness             <= 23'd8192;
         cfg_ff.inv_sharpness         <= 24'd32768;
         cfg_ff.leak_potential        <= -24'sd286720;
         cfg_ff.critical_potential    <= -24'sd204800;
         cfg_ff.lower_bound_potential <= -24'sd409600;
         cfg_ff.threshold_potential   <= 24'sd81920;
         cfg_ff.reset_potential       <= -24'sd286720;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LEAK_GAIN:  cfg_ff.leak_gain             <= csr_data[15:0];
            CSR_SHARPNESS:  cfg_ff.sharpness             <= csr_data[22:0];
            CSR_INV_SHARP:  cfg_ff.inv_sharpness         <= csr_data;
            CSR_LEAK_POT:   cfg_ff.leak_potential        <= csr_data;
            CSR_CRIT_POT:   cfg_ff.critical_potential    <= csr_data;
            CSR_LOWER_POT:  cfg_ff.lower_bound_potential <= csr_data;
            CSR_THRESH_POT: cfg_ff.threshold_potential   <= csr_data;
            CSR_RESET_POT:  cfg_ff.reset_potential       <= csr_data;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: sv/eif_state_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eif_state_mem
// Per-neuron state memory: one write port, one registered read port, and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module eif_state_mem (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [eif_pkg::IDX_W-1:0] rd_addr,
   output eif_pkg::state_type             rd_data,
   input  wire logic                      wr_en,
   input  wire logic [eif_pkg::IDX_W-1:0] wr_addr,
   input  eif_pkg::state_type             wr_data,
   output logic                           busy
);
   import eif_pkg::*;

   state_type        mem [NEURONS];
   state_type        rd_ff;
   logic [CLR_W-1:0] clr_ff;
   logic [CLR_W-1:0] clr_in;

   assign busy    = (clr_ff != CLR_W'(NEURONS));
   assign rd_data = rd_ff;
   assign clr_in  = clr_ff + CLR_W'(1);

   // advance the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (busy) begin
         clr_ff <= clr_in;
      end
   end

   // write: sweep first, then the pipeline
   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_ff[IDX_W-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: sv/eif_exp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eif_exp
// Five-stage fixed-point exponential: scale to base two, cubic for the
// fraction, shift by the integer part. Output is Q.16 capped at 2^31-1.
// ----------------------------------------------------------------------------
module eif_exp (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [49:0] arg_prod,
   output logic [30:0]             result
);
   import eif_pkg::*;

   localparam logic signed [37:0] X_HI = 38'sd2097152;
   localparam logic signed [37:0] X_LO = -38'sd2097152;

   logic signed [37:0] x_full;
   logic signed [22:0] x_clamp;
   logic signed [41:0] yp_ff;
   logic signed [23:0] y_val;
   logic signed [7:0]  k1_ff, k2_ff, k3_ff;
   logic [15:0]        f1_ff, f2_ff;
   logic [28:0]        prod1;
   logic [14:0]        p1_ff;
   logic [30:0]        prod2;
   logic [16:0]        p2_ff;
   logic [32:0]        prod3;
   logic [17:0]        m_ff;
   logic [32:0]        shl;
   logic [7:0]         neg_k;
   logic [30:0]        e_in;
   logic [30:0]        e_ff;

   // floor by 2^12 and clamp to +/- 2^21
   always_comb begin
      x_full = arg_prod[49:12];
      if (x_full > X_HI) begin
         x_clamp = 23'sd2097152;
      end else if (x_full < X_LO) begin
         x_clamp = -23'sd2097152;
      end else begin
         x_clamp = x_full[22:0];
      end
   end

   assign y_val = yp_ff[39:16];
   assign prod1 = 29'd5179 * 29'(y_val[15:0]);
   assign prod2 = 31'(p1_ff) * 31'(f1_ff);
   assign prod3 = 33'(p2_ff) * 33'(f2_ff);

   // shift the mantissa by the integer exponent
   always_comb begin
      shl   = 33'(m_ff) << k3_ff[3:0];
      neg_k = 8'(-k3_ff);
      if (k3_ff >= 8'sd15) begin
         e_in = 31'h7FFFFFFF;
      end else if (k3_ff >= 8'sd0) begin
         e_in = (shl > 33'h07FFFFFFF) ? 31'h7FFFFFFF : shl[30:0];
      end else if (k3_ff <= -8'sd18) begin
         e_in = '0;
      end else begin
         e_in = 31'(m_ff >> neg_k[4:0]);
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (enable) begin
         yp_ff <= x_clamp * 19'sd94548;
         k1_ff <= y_val[23:16];
         f1_ff <= y_val[15:0];
         p1_ff <= 15'(15'd14822 + 15'(prod1[28:16]));
         k2_ff <= k1_ff;
         f2_ff <= f1_ff;
         p2_ff <= 17'(17'd45560 + 17'(prod2[30:16]));
         k3_ff <= k2_ff;
         m_ff  <= 18'(18'd65536 + 18'(prod3[32:16]));
         e_ff  <= e_in;
      end
   end

   assign result = e_ff;

endmodule
`default_nettype wire

// File: sv/exp_integrate_fire_neuron_update_unit.sv
`default_nettype none
// An accepted item passes through the compute stages, then the output register.
// Throughput: one item per cycle for distinct neurons unless the result register
// stalls; an item whose neuron is still in the 11 compute stages waits until that
// update is written back. Reset: after reset the state memory is swept, one neuron
// a cycle; no item is accepted during the sweep, configuration writes are.
// ----------------------------------------------------------------------------
// exp_integrate_fire_neuron_update_unit
// Pipelined exponential integrate-and-fire update of a neuron population.
// ----------------------------------------------------------------------------
module exp_integrate_fire_neuron_update_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  eif_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output eif_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [eif_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [23:0]                   csr_data
);
   import eif_pkg::*;

   localparam int LAST = 11;

   typedef struct packed {
      logic               valid;
      logic               in_range;
      logic [IDX_W-1:0]   idx;
      logic [31:0]        now;
      logic signed [23:0] syn;
      logic signed [23:0] v;
      logic               refr;
      logic               has;
      logic [31:0]        last;
   } pipe_type;

   cfg_type            cfg;
   pipe_type           pipe_ff [1:LAST];
   pipe_type           pipe_in [1:LAST];
   state_type          rd_data;
   state_type          wr_data;
   logic               wr_en;
   logic               busy;
   logic               advance;
   logic               hazard;
   logic               accept;
   logic [31:0]        since;
   logic signed [24:0] d_ff;
   logic signed [49:0] xp_ff;
   logic [30:0]        e_val;
   logic [53:0]        t_prod;
   logic [37:0]        t_ff;
   logic signed [39:0] inner_ff;
   logic signed [56:0] lp_ff;
   logic signed [41:0] nv;
   logic signed [23:0] sat_v;
   logic signed [23:0] bound_v;
   logic               fired;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   eif_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   eif_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_addr (req_data.neuron_index),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (pipe_ff[LAST].idx),
      .wr_data (wr_data),
      .busy    (busy)
   );

   eif_exp u_exp (
      .clock    (clock),
      .enable   (advance),
      .arg_prod (xp_ff),
      .result   (e_val)
   );

   // whole pipeline moves unless the result register is stuck
   assign advance = !rsp_valid_ff || rsp_ready;

   // hold an item whose neuron is still being updated
   always_comb begin
      hazard = 1'b0;
      for (int i = 1; i <= LAST; i++) begin
         if (pipe_ff[i].valid && pipe_ff[i].idx == req_data.neuron_index) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_ready = advance && !busy && !hazard;
   assign accept    = req_valid && req_ready;

   // refractory window test on the stored state
   assign since = pipe_ff[1].now - rd_data.last_spike;

   // next stage contents
   always_comb begin
      pipe_in[1].valid    = accept;
      pipe_in[1].in_range = (32'(req_data.neuron_index) < NEURONS);
      pipe_in[1].idx      = req_data.neuron_index;
      pipe_in[1].now      = req_data.step_count;
      pipe_in[1].syn      = req_data.synaptic_input;
      pipe_in[1].v        = '0;
      pipe_in[1].refr     = 1'b0;
      pipe_in[1].has      = 1'b0;
      pipe_in[1].last     = '0;
      pipe_in[2]          = pipe_ff[1];
      pipe_in[2].v        = rd_data.potential;
      pipe_in[2].has      = rd_data.has_spiked;
      pipe_in[2].last     = rd_data.last_spike;
      pipe_in[2].refr     = rd_data.has_spiked && (since <= REFRACTORY_STEPS);
      for (int i = 3; i <= LAST; i++) begin
         pipe_in[i] = pipe_ff[i-1];
      end
   end

   // sideband stages, valid bits cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAST; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int i = 1; i <= LAST; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign t_prod = cfg.sharpness * e_val;

   // arithmetic stages
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff     <= 25'(rd_data.potential) - 25'(cfg.critical_potential);
         xp_ff    <= d_ff * $signed({1'b0, cfg.inv_sharpness});
         t_ff     <= t_prod[53:16];
         inner_ff <= 40'(cfg.leak_potential) - 40'(pipe_ff[9].v)
                     + $signed({2'b00, t_ff});
         lp_ff    <= inner_ff * $signed({1'b0, cfg.leak_gain});
      end
   end

   // final sum, saturate, floor and threshold
   always_comb begin
      nv = 42'(pipe_ff[LAST].v) + 42'($signed(lp_ff[56:16])) + 42'(pipe_ff[LAST].syn);
      if (nv > Q_MAX) begin
         sat_v = 24'sd8388607;
      end else if (nv < Q_MIN) begin
         sat_v = -24'sd8388608;
      end else begin
         sat_v = nv[23:0];
      end
      bound_v = (sat_v < cfg.lower_bound_potential) ? cfg.lower_bound_potential : sat_v;
      fired   = bound_v > cfg.threshold_potential;
   end

   // result and write back
   always_comb begin
      rsp_in.neuron_number = pipe_ff[LAST].idx;
      rsp_in.spiked        = 1'b0;
      rsp_in.new_potential = '0;
      wr_data.has_spiked   = pipe_ff[LAST].has;
      wr_data.last_spike   = pipe_ff[LAST].last;
      wr_data.potential    = bound_v;
      if (pipe_ff[LAST].in_range) begin
         if (pipe_ff[LAST].refr) begin
            rsp_in.new_potential = pipe_ff[LAST].v;
         end else if (fired) begin
            rsp_in.spiked        = 1'b1;
            rsp_in.new_potential = cfg.reset_potential;
            wr_data.has_spiked   = 1'b1;
            wr_data.last_spike   = pipe_ff[LAST].now;
            wr_data.potential    = cfg.reset_potential;
         end else begin
            rsp_in.new_potential = bound_v;
         end
      end
   end

   assign wr_en = advance && pipe_ff[LAST].valid && pipe_ff[LAST].in_range
                  && !pipe_ff[LAST].refr;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pipe_ff[LAST].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // no item enters while the sweep runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready) else $error("item accepted during clear sweep");

   // a stall freezes the last stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!advance && pipe_ff[LAST].valid) |=> pipe_ff[LAST].valid)
      else $error("last stage lost an item under stall");

   // the last stage always lands in the result register
   a_last_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && pipe_ff[LAST].valid) |=> rsp_valid_ff)
      else $error("result dropped");

   // no pipeline write during the sweep
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !pipe_ff[LAST].valid) else $error("write during clear sweep");

endmodule
`default_nettype wire
